FILE: rtl/assert_macros.svh
// assertion macros used by the host table rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that a condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/rht_pkg.sv
// types and constants of the host table
// no dependencies; imported by the engine, the top level and the testbench
`default_nettype none

package rht_pkg;

  typedef enum logic [1:0] {
    CMD_FIND      = 2'd0,
    CMD_MAKE      = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_RESET_NET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  localparam logic [31:0] NET_MASK_RESET = 32'hFF00_0000;
  localparam logic [7:0]  REFS_MAX       = 8'hFF;
  localparam logic [6:0]  RCOUNT_MAX     = 7'd127;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] host_address;
    logic [31:0] network_value;
  } item_t;

  typedef struct packed {
    status_t     status_code;
    logic [5:0]  entry_index;
    logic [7:0]  ref_count;
    logic [6:0]  reset_count;
  } result_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  refs;
    logic        up;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/rht_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rht_engine.sv
// scan sequencer of the host table: clearing pass, table scan, write back
// depends on rht_pkg, rht_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rht_engine #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [31:0]      net_mask,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rht_pkg::item_t   in_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output rht_pkg::result_t      res_data
);

  import rht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             issue_r;
  logic             dv_r;
  logic [IDX_W-1:0] dv_idx_r;
  item_t            item_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           hit_word_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [6:0]       rcount_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_word;
  logic             net_match;
  logic             addr_match;
  logic [7:0]       refs_inc;
  logic [7:0]       refs_dec;

  rht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_word    = entry_t'(ram_rdata);
  assign net_match  = (rd_word.addr & net_mask) == item_r.network_value;
  assign addr_match = rd_word.addr == item_r.host_address;
  assign refs_inc   = (hit_word_r.refs == REFS_MAX) ? REFS_MAX : hit_word_r.refs + 8'd1;
  assign refs_dec   = (hit_word_r.refs == 8'd0) ? 8'd0 : hit_word_r.refs - 8'd1;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_APPLY);

  // write port and result; the apply write repeats harmlessly while the result waits
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_r;
    ram_wdata = '0;
    res_data  = '{status_code: STATUS_OK, entry_index: '0, ref_count: '0, reset_count: '0};
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_SCAN: begin
        if (dv_r && item_r.cmd == CMD_RESET_NET && net_match) begin
          ram_we    = 1'b1;
          ram_waddr = dv_idx_r;
          ram_wdata = '{addr: rd_word.addr, refs: rd_word.refs, up: 1'b0};
        end
      end
      ST_APPLY: begin
        case (item_r.cmd)
          CMD_FIND: begin
            if (hit_r) begin
              res_data.entry_index = 6'(hit_idx_r);
              res_data.ref_count   = hit_word_r.refs;
            end else begin
              res_data.status_code = STATUS_NOT_FOUND;
            end
          end
          CMD_MAKE: begin
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_r;
              ram_wdata = '{addr: hit_word_r.addr, refs: refs_inc, up: hit_word_r.up};
              res_data.entry_index = 6'(hit_idx_r);
              res_data.ref_count   = refs_inc;
            end else if (free_r) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_r;
              ram_wdata = '{addr: item_r.host_address, refs: 8'd1, up: 1'b1};
              res_data.entry_index = 6'(free_idx_r);
              res_data.ref_count   = 8'd1;
            end else begin
              res_data.status_code = STATUS_FULL;
            end
          end
          CMD_FREE: begin
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_r;
              if (refs_dec == 8'd0) begin
                ram_wdata = '0;
              end else begin
                ram_wdata = '{addr: hit_word_r.addr, refs: refs_dec, up: hit_word_r.up};
              end
              res_data.entry_index = 6'(hit_idx_r);
              res_data.ref_count   = refs_dec;
            end else begin
              res_data.status_code = STATUS_NOT_FOUND;
            end
          end
          default: begin
            res_data.reset_count = rcount_r;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      rd_addr_r <= '0;
      issue_r   <= 1'b0;
      dv_r      <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          rd_addr_r <= rd_addr_r + IDX_W'(1);
          if (rd_addr_r == LAST_IDX) begin
            rd_addr_r <= '0;
            state_r   <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item_r    <= in_data;
            hit_r     <= 1'b0;
            free_r    <= 1'b0;
            rcount_r  <= '0;
            rd_addr_r <= '0;
            issue_r   <= 1'b1;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          dv_r     <= issue_r;
          dv_idx_r <= rd_addr_r;
          if (issue_r) begin
            rd_addr_r <= rd_addr_r + IDX_W'(1);
            if (rd_addr_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end
          end
          if (dv_r) begin
            if (item_r.cmd == CMD_RESET_NET) begin
              if (net_match && rcount_r != RCOUNT_MAX) begin
                rcount_r <= rcount_r + 7'd1;
              end
            end else begin
              if (!hit_r && addr_match) begin
                hit_r      <= 1'b1;
                hit_idx_r  <= dv_idx_r;
                hit_word_r <= rd_word;
              end
              // free slots are claimed from index 1 upwards
              if (!free_r && dv_idx_r != '0 && rd_word.refs == 8'd0) begin
                free_r     <= 1'b1;
                free_idx_r <= dv_idx_r;
              end
            end
            if (dv_idx_r == LAST_IDX) begin
              state_r <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (res_ready) begin
            rd_addr_r <= '0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_no_write_idle, clk, rst_n, state_r == ST_IDLE && ram_we,
                "table written while idle")
  `ASSERT_CLK(a_dv_in_scan, clk, rst_n, dv_r |-> state_r == ST_SCAN,
              "read data valid outside a scan")
  `ASSERT_CLK(a_accept_starts_scan, clk, rst_n,
              (in_valid && in_ready) |=> (state_r == ST_SCAN && issue_r),
              "accepted request did not start a scan")
  `ASSERT_CLK(a_full_only_make, clk, rst_n,
              (res_valid && res_data.status_code == STATUS_FULL) |-> item_r.cmd == CMD_MAKE,
              "table full reported for a command other than make")

endmodule

`default_nettype wire

FILE: rtl/refcounted_host_table.sv
// reference-counted host table, top level with mask register and output register
// each request runs a full table scan that reads one entry a cycle, then its result is applied
// the next request is taken only once the engine has passed that result to the output register;
// a new request is taken while the previous result still waits at the output
// reset: synchronous clearing pass over every table entry, no request taken meanwhile
// depends on rht_pkg and rht_engine
`default_nettype none

module refcounted_host_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rht_pkg::item_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rht_pkg::result_t      out_data
);

  import rht_pkg::*;

  logic [31:0] net_mask_r;
  logic        out_valid_r;
  result_t     out_data_r;
  logic        res_valid;
  logic        res_ready;
  result_t     res_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rht_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .net_mask  (net_mask_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_mask_r  <= NET_MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        net_mask_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

FILE: verif/refcounted_host_table_tb.sv
// self-checking testbench for refcounted_host_table: directed table, then random requests
// checked against an in-bench model of the host table; needs rht_pkg and the block rtl
module refcounted_host_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rht_pkg::*;

  localparam int TABLE_ENTRIES  = 64;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int LONG_HOLD      = 600;
  // longest legal quiet stretch is the long receiver hold; leave a wide margin
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    item_t   req;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  item_t       in_data;
  logic        out_valid;
  logic        out_ready;
  result_t     out_data;

  // model of the table
  logic [31:0] host_addr_tbl [TABLE_ENTRIES];
  logic [7:0]  host_refs_tbl [TABLE_ENTRIES];
  logic        host_up_tbl   [TABLE_ENTRIES];
  logic [31:0] net_mask_q;

  result_t     expected_results [$];
  result_t     head_exp;
  dir_row_t    directed_rows [$];
  logic [31:0] addr_pool [$];

  bit sender_idle_en;
  bit recv_idle_en;
  bit long_hold_req;

  int errors;
  int n_requests;
  int n_results;
  int n_full;
  int n_not_found;
  int n_mask_writes;
  int idle_cycles;

  refcounted_host_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_table_model();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      host_addr_tbl[i] = '0;
      host_refs_tbl[i] = '0;
      host_up_tbl[i]   = 1'b0;
    end
    net_mask_q = NET_MASK_RESET;
  endfunction

  // updates the table model and returns the reply the block should give
  function automatic result_t apply_host_op(item_t req);
    result_t r;
    int      hit;
    r = '0;
    r.status_code = STATUS_OK;
    hit = -1;
    if (req.cmd == CMD_RESET_NET) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if ((host_addr_tbl[i] & net_mask_q) == req.network_value) begin
          host_up_tbl[i] = 1'b0;
          if (r.reset_count < RCOUNT_MAX) r.reset_count = r.reset_count + 7'd1;
        end
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && host_addr_tbl[i] == req.host_address) hit = i;
      end
      case (req.cmd)
        CMD_FIND: begin
          if (hit < 0) begin
            r.status_code = STATUS_NOT_FOUND;
          end else begin
            r.entry_index = 6'(hit);
            r.ref_count   = host_refs_tbl[hit];
          end
        end
        CMD_MAKE: begin
          if (hit >= 0) begin
            if (host_refs_tbl[hit] < REFS_MAX) host_refs_tbl[hit] = host_refs_tbl[hit] + 8'd1;
            r.entry_index = 6'(hit);
            r.ref_count   = host_refs_tbl[hit];
          end else begin
            // claim the first unreferenced slot, slot 0 is never handed out
            r.status_code = STATUS_FULL;
            for (int i = 1; i < TABLE_ENTRIES; i++) begin
              if (r.status_code == STATUS_FULL && host_refs_tbl[i] == 0) begin
                host_addr_tbl[i] = req.host_address;
                host_refs_tbl[i] = 8'd1;
                host_up_tbl[i]   = 1'b1;
                r.status_code    = STATUS_OK;
                r.entry_index    = 6'(i);
                r.ref_count      = 8'd1;
              end
            end
          end
        end
        CMD_FREE: begin
          if (hit < 0) begin
            r.status_code = STATUS_NOT_FOUND;
          end else begin
            if (host_refs_tbl[hit] > 0) host_refs_tbl[hit] = host_refs_tbl[hit] - 8'd1;
            if (host_refs_tbl[hit] == 0) begin
              host_addr_tbl[hit] = '0;
              host_up_tbl[hit]   = 1'b0;
            end
            r.entry_index = 6'(hit);
            r.ref_count   = host_refs_tbl[hit];
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(cmd_t c, logic [31:0] addr, logic [31:0] net,
                                       bit typed, status_t st, logic [5:0] idx,
                                       logic [7:0] refs, logic [6:0] rcount);
    dir_row_t row;
    row.req.cmd           = c;
    row.req.host_address  = addr;
    row.req.network_value = net;
    row.typed             = typed;
    row.res.status_code   = st;
    row.res.entry_index   = idx;
    row.res.ref_count     = refs;
    row.res.reset_count   = rcount;
    return row;
  endfunction

  function automatic item_t random_request();
    item_t req;
    int    sel;
    sel = $urandom_range(0, 99);
    req.host_address  = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    req.network_value = addr_pool[$urandom_range(0, addr_pool.size() - 1)] & net_mask_q;
    if (sel < 10) begin
      // noise
      req.cmd           = cmd_t'($urandom_range(0, 3));
      req.host_address  = $urandom;
      req.network_value = $urandom;
    end else if (sel < 50) begin
      req.cmd = CMD_MAKE;
    end else if (sel < 68) begin
      req.cmd = CMD_FIND;
    end else if (sel < 92) begin
      req.cmd = CMD_FREE;
    end else begin
      req.cmd = CMD_RESET_NET;
    end
    return req;
  endfunction

  // two shared networks so that a network reset hits several hosts
  task automatic fill_addr_pool(input int n);
    logic [31:0] a;
    addr_pool.delete();
    repeat (n) begin
      a = $urandom;
      case ($urandom_range(0, 3))
        0: a[31:24] = 8'h0A;
        1: a[31:24] = 8'hC0;
        default: ;
      endcase
      addr_pool.push_back(a);
    end
  endtask

  // valid stays up across back-to-back requests, dropped only for a gap
  task automatic send_request(input item_t req, input bit typed, input result_t typed_res);
    result_t pred;
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pred = apply_host_op(req);
    expected_results.push_back(typed ? typed_res : pred);
    n_requests++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_request(random_request(), 1'b0, '0);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_net_mask(input logic [31:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    net_mask_q  = value;
    n_mask_writes++;
  endtask

  // result side: ready bursts, random stalls and one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.status_code == STATUS_FULL) n_full++;
      if (out_data.status_code == STATUS_NOT_FOUND) n_not_found++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status_code %0d entry_index %0d",
               out_data.status_code, out_data.entry_index);
        errors++;
      end else begin
        head_exp = expected_results.pop_front();
        if (out_data.status_code !== head_exp.status_code) begin
          $error("status_code: expected %0d, got %0d", head_exp.status_code,
                 out_data.status_code);
          errors++;
        end
        if (out_data.entry_index !== head_exp.entry_index) begin
          $error("entry_index: expected %0d, got %0d", head_exp.entry_index,
                 out_data.entry_index);
          errors++;
        end
        if (out_data.ref_count !== head_exp.ref_count) begin
          $error("ref_count: expected %0d, got %0d", head_exp.ref_count, out_data.ref_count);
          errors++;
        end
        if (out_data.reset_count !== head_exp.reset_count) begin
          $error("reset_count: expected %0d, got %0d", head_exp.reset_count,
                 out_data.reset_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    idle_cycles    = 0;
    errors         = 0;
    n_requests     = 0;
    n_results      = 0;
    n_full         = 0;
    n_not_found    = 0;
    n_mask_writes  = 0;
    sender_idle_en = 1'b1;
    recv_idle_en   = 1'b1;
    long_hold_req  = 1'b0;
    clear_table_model();

    // fresh table: every slot holds address 0 with no references
    directed_rows.push_back(dir_row(CMD_FIND, 32'h0, 32'h0, 1, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FIND, '1, 32'h0, 1, STATUS_NOT_FOUND, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, '1, 32'h0, 1, STATUS_NOT_FOUND, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_RESET_NET, 32'h0, '1, 1, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_RESET_NET, '1, 32'h0, 1, STATUS_OK, 0, 0, 64));
    directed_rows.push_back(dir_row(CMD_MAKE, '1, 32'h0, 1, STATUS_OK, 1, 1, 0));
    directed_rows.push_back(dir_row(CMD_MAKE, '1, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FIND, '1, '1, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_MAKE, 32'h0000_0001, 32'h0, 0, STATUS_OK, 0, 0, 0));
    // address 0 hits slot 0 even though it was never made
    directed_rows.push_back(dir_row(CMD_MAKE, 32'h0, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_MAKE, 32'h0, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, 32'h0, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, 32'h0, 32'h0, 0, STATUS_OK, 0, 0, 0));
    // free on a count already at zero
    directed_rows.push_back(dir_row(CMD_FREE, 32'h0, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_MAKE, 32'h8000_0000, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_RESET_NET, 32'h0, 32'hFF00_0000, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_RESET_NET, 32'h0, 32'h8000_0000, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_RESET_NET, '1, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, '1, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, '1, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FIND, '1, 32'h0, 1, STATUS_NOT_FOUND, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_MAKE, 32'h1234_5678, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FREE, 32'h0000_0001, 32'h0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(dir_row(CMD_FIND, 32'h0000_0001, '1, 0, STATUS_OK, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // all-ones mask; one host made over and over to push its count into saturation
    write_net_mask('1);
    fill_addr_pool(10);
    addr_pool.push_back('0);
    addr_pool.push_back('1);
    repeat (256) send_request('{cmd: CMD_MAKE, host_address: addr_pool[0], network_value: '0},
                              1'b0, '0);
    run_random(8);
    // receiver holds off while requests keep coming, so the input backs up
    long_hold_req = 1'b1;
    run_random(10);

    // all-zero mask; overfill the table, reset every network, then work on the same hosts
    write_net_mask('0);
    fill_addr_pool(66);
    foreach (addr_pool[i]) send_request('{cmd: CMD_MAKE, host_address: addr_pool[i],
                                          network_value: '0}, 1'b0, '0);
    send_request('{cmd: CMD_RESET_NET, host_address: '0, network_value: '0}, 1'b0, '0);
    send_request('{cmd: CMD_RESET_NET, host_address: '0, network_value: $urandom | 32'h1},
                 1'b0, '0);
    run_random(20);

    write_net_mask($urandom);
    run_random(20);

    // back to the reset mask, no idling on either side
    write_net_mask(NET_MASK_RESET);
    sender_idle_en = 1'b0;
    recv_idle_en   = 1'b0;
    run_random(20);

    wait_results_drained();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("%0d requests (%0d directed), %0d results checked, %0d table-full, %0d not-found",
             n_requests, directed_rows.size(), n_results, n_full, n_not_found);
    $display("net mask written %0d times: all ones, all zeros, random and reset value",
             n_mask_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
